FILE: hw/rtl/rnmr_pkg.sv
// Shared constants and types for the raw noise model regression block.
package rnmr_pkg;

  // Default sizing
  localparam int unsigned MAX_SAMPLES_DEF = 16777216;
  localparam int unsigned CHANNELS_DEF    = 4;
  localparam int unsigned NUM_IN_CH       = 4;

  // Field widths
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned VAR_W   = 24;
  localparam int unsigned OFF_W   = 24;
  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned KEPT_W  = 25;

  // Accumulator widths
  localparam int unsigned SMEAN_W = 40;
  localparam int unsigned SVAR_W  = 40;
  localparam int unsigned SMSQ_W  = 56;
  localparam int unsigned SMV_W   = 56;
  localparam int unsigned SRES_W  = 64;
  localparam int unsigned RMS_W   = 32;
  localparam int unsigned RESID_W = 32;

  // Shared arithmetic unit widths
  localparam int unsigned OPND_W = 64;
  localparam int unsigned PROD_W = 128;
  localparam int unsigned DIG_W  = 8;

  // Stream and register port widths
  localparam int unsigned IN_TDATA_W  = 160;
  localparam int unsigned OUT_TDATA_W = 256;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  // Register indexes (word address)
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MIN_MEAN = 2'd0;
  localparam reg_idx_t REG_MAX_MEAN = 2'd1;
  localparam reg_idx_t REG_VAR_LIM  = 2'd2;

  // Register reset values
  localparam logic [MEAN_W-1:0] MIN_MEAN_RST = 16'd66;
  localparam logic [MEAN_W-1:0] MAX_MEAN_RST = 16'd32768;
  localparam logic [VAR_W-1:0]  VAR_LIM_RST  = 24'd16777;

  // Pass codes
  typedef enum logic [1:0] {
    PASS_FIT,
    PASS_RESID,
    PASS_REFIT
  } pass_e;

endpackage

FILE: hw/rtl/rnmr_mul.sv
// Shared digit-serial multiplier: eight bits of the b operand per cycle.
module rnmr_mul
  import rnmr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OPND_W-1:0] a_i,
  input  logic [OPND_W-1:0] b_i,
  output logic              busy_o,
  output logic [PROD_W-1:0] p_o
);

  logic              busy_q, busy_d;
  logic [PROD_W-1:0] a_q, a_d, acc_q, acc_d, pp;
  logic [OPND_W-1:0] b_q, b_d;

  assign pp = a_q * b_q[DIG_W-1:0];

  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = PROD_W'(a_i);
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      // stop as soon as no digit of b is left
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        acc_d = acc_q + pp;
        a_d   = a_q << DIG_W;
        b_d   = b_q >> DIG_W;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;

endmodule

FILE: hw/rtl/rnmr_div.sv
// Shared restoring divider: one quotient bit per cycle.
module rnmr_div
  import rnmr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] num_i,
  input  logic [PROD_W-1:0] den_i,
  output logic              busy_o,
  output logic [PROD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(PROD_W);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] rem_q, rem_d, nq_q, nq_d, den_q, den_d, rem_sh;
  logic              ge;

  assign rem_sh = {rem_q[PROD_W-2:0], nq_q[PROD_W-1]};
  assign ge     = rem_sh >= den_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      nq_d   = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      // shift the numerator out and the quotient in
      rem_d = ge ? rem_sh - den_q : rem_sh;
      nq_d  = {nq_q[PROD_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = nq_q;

endmodule

FILE: hw/rtl/rnmr_sqrt.sv
// Shared integer square root: one result bit per cycle.
module rnmr_sqrt
  import rnmr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OPND_W-1:0] val_i,
  output logic              busy_o,
  output logic [RMS_W-1:0]  root_o
);

  logic              busy_q, busy_d;
  logic [OPND_W-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d, trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = val_i;
      res_d  = '0;
      bit_d  = OPND_W'(1) << (OPND_W - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = res_q[RMS_W-1:0];

endmodule

FILE: hw/rtl/raw_noise_model_regression.sv
// Top level: three-pass per-channel linear noise model fit (var = A + B*mean).
// A rejected sample skips the per-channel products; a kept one waits on the shared multiplier
//   for each channel in the fit pass, the residual pass and the refit.
// Pass end: a divide plus a root per channel for the RMS, two divides and five products
//   per channel for a fit; s_axis_tready_o is high only in idle.
// Reset: asynchronous, clears pass, counts, sums and stored model; no clearing pass.
module raw_noise_model_regression
  import rnmr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned CHANNELS    = CHANNELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave stream: sample transfer
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: mean_0, mean_1, mean_2, mean_3, var_0, var_1, var_2, var_3
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tlast: pass_end
  input  logic                   s_axis_tlast_i,
  // master stream: model transfer
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: offset_0..3, slope_0..3, kept_count, degenerate, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CMP_W    = (CNT_W > KEPT_W) ? CNT_W : KEPT_W;
  localparam int unsigned FRAC_SH  = 16;
  localparam int unsigned RMS_SH   = 24;
  localparam int unsigned POS_W    = 50;
  localparam int unsigned RFULL_W  = POS_W - FRAC_SH;
  localparam int unsigned KEPT_MAX = (1 << KEPT_W) - 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RES_MUL, S_RES_SQ, S_RES_ACC, S_ACC_MM, S_ACC_MV, S_ACC_UPD, S_END,
    S_RMS_DIV, S_RMS_SQRT, S_RMS_WR,
    S_FIT_NXX, S_FIT_XX, S_FIT_DEN, S_FIT_XY, S_FIT_BDIV, S_FIT_BQ, S_FIT_BX,
    S_FIT_ADIV, S_FIT_AQ, S_FIT_WR, S_PASS_DONE, S_WAIT
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MEAN_W-1:0] min_mean_q, max_mean_q;
  logic [VAR_W-1:0]  var_lim_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mean_q <= MIN_MEAN_RST;
      max_mean_q <= MAX_MEAN_RST;
      var_lim_q  <= VAR_LIM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MIN_MEAN: min_mean_q <= pwdata[MEAN_W-1:0];
        REG_MAX_MEAN: max_mean_q <= pwdata[MEAN_W-1:0];
        REG_VAR_LIM:  var_lim_q  <= pwdata[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_MEAN: prdata = APB_DW'(min_mean_q);
      REG_MAX_MEAN: prdata = APB_DW'(max_mean_q);
      REG_VAR_LIM:  prdata = APB_DW'(var_lim_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and per-channel accumulators
  // ---------------------------------------------------------------------------
  state_e            state_q, ret_q;
  pass_e             pass_q;
  logic [CH_W-1:0]   ch_q;
  logic [CNT_W-1:0]  count_q;
  logic              keep_q, last_q, degen_q, out_valid_q;

  logic [SMEAN_W-1:0] sum_mean_q   [CHANNELS];
  logic [SVAR_W-1:0]  sum_var_q    [CHANNELS];
  logic [SMSQ_W-1:0]  sum_msq_q    [CHANNELS];
  logic [SMV_W-1:0]   sum_mv_q     [CHANNELS];
  logic [SRES_W-1:0]  sum_res_q    [CHANNELS];
  logic [OFF_W-1:0]   first_off_q  [CHANNELS];
  logic [SLOPE_W-1:0] first_slp_q  [CHANNELS];
  logic [RMS_W-1:0]   rms_q        [CHANNELS];

  // payload registers
  logic [MEAN_W-1:0]  mean_q [CHANNELS];
  logic [VAR_W-1:0]   var_q  [CHANNELS];
  logic [2*MEAN_W-1:0] mm_q;
  logic [PROD_W-1:0]  t0_q, den_q;
  logic [OFF_W-1:0]   aq_q;
  logic [SLOPE_W-1:0] bq_q;
  logic [OUT_TDATA_W-1:0] out_q;

  // shared units
  logic              mul_start, div_start, sqrt_start;
  logic              mul_busy, div_busy, sqrt_busy, any_busy;
  logic [OPND_W-1:0] mul_a, mul_b, sqrt_v;
  logic [PROD_W-1:0] mul_p, div_n, div_d, div_q;
  logic [RMS_W-1:0]  sqrt_root;

  assign any_busy = mul_busy || div_busy || sqrt_busy;

  // ---------------------------------------------------------------------------
  // Input transfer and sample screening
  // ---------------------------------------------------------------------------
  logic in_xfer, in_keep, ch_last;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign ch_last         = (ch_q == CH_W'(CHANNELS - 1));

  always_comb begin
    logic [MEAN_W-1:0] m;
    logic [VAR_W-1:0]  v;
    in_keep = (count_q < CNT_W'(MAX_SAMPLES));
    for (int c = 0; c < CHANNELS; c++) begin
      m = s_axis_tdata_i[c*MEAN_W +: MEAN_W];
      v = s_axis_tdata_i[NUM_IN_CH*MEAN_W + c*VAR_W +: VAR_W];
      if (m < min_mean_q || m > max_mean_q || v > var_lim_q) begin
        in_keep = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel-selected operands and datapath glue
  // ---------------------------------------------------------------------------
  logic [MEAN_W-1:0]  m_sel;
  logic [VAR_W-1:0]   v_sel;
  logic [SMEAN_W-1:0] sx_sel;
  logic [SVAR_W-1:0]  sy_sel;
  logic [SMSQ_W-1:0]  sxx_sel;
  logic [SMV_W-1:0]   sxy_sel;

  assign m_sel   = mean_q[ch_q];
  assign v_sel   = var_q[ch_q];
  assign sx_sel  = sum_mean_q[ch_q];
  assign sy_sel  = sum_var_q[ch_q];
  assign sxx_sel = sum_msq_q[ch_q];
  assign sxy_sel = sum_mv_q[ch_q];

  // residual against the first-pass model, rounded half up from Q.16 to an integer
  logic [POS_W-1:0]   pos, neg, mag, rnd;
  logic [RFULL_W-1:0] r_full;
  logic [RESID_W-1:0] resid;
  logic               sq_fail;

  assign pos    = POS_W'({first_off_q[ch_q], FRAC_SH'(0)}) + POS_W'(mul_p[SLOPE_W+MEAN_W-1:0]);
  assign neg    = POS_W'({v_sel, FRAC_SH'(0)});
  assign mag    = (pos >= neg) ? pos - neg : neg - pos;
  assign rnd    = mag + POS_W'(1 << (FRAC_SH - 1));
  assign r_full = rnd[POS_W-1:FRAC_SH];
  assign resid  = (|r_full[RFULL_W-1:RESID_W]) ? '1 : r_full[RESID_W-1:0];
  assign sq_fail = mul_p[SRES_W-1:0] > SRES_W'({rms_q[ch_q], RMS_SH'(0)});

  // fit numerators, divisors and saturated quotients
  logic               t0_gt, sy_gt;
  logic [PROD_W-1:0]  sy_ext, b_num, a_num, a_den;
  logic [SLOPE_W-1:0] bq_sat;
  logic [OFF_W-1:0]   aq_sat;

  assign t0_gt  = t0_q > mul_p;
  assign sy_ext = PROD_W'({sy_sel, FRAC_SH'(0)});
  assign sy_gt  = sy_ext > mul_p;
  assign b_num  = (t0_q - mul_p) << FRAC_SH;
  assign a_num  = sy_ext - mul_p;
  assign a_den  = PROD_W'({count_q, FRAC_SH'(0)});

  always_comb begin
    bq_sat = (|div_q[PROD_W-1:SLOPE_W]) ? '1 : div_q[SLOPE_W-1:0];
    if (bq_sat == '0) bq_sat = SLOPE_W'(1);
    aq_sat = (|div_q[PROD_W-1:OFF_W]) ? '1 : div_q[OFF_W-1:0];
    if (aq_sat == '0) aq_sat = OFF_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Unit issue: each issuing state loads one unit and parks in S_WAIT
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_n      = '0;
    div_d      = '0;
    sqrt_v     = div_q[OPND_W-1:0];
    case (state_q)
      S_RES_MUL: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(first_slp_q[ch_q]);
        mul_b     = OPND_W'(m_sel);
      end
      S_RES_SQ: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(resid);
        mul_b     = OPND_W'(resid);
      end
      S_ACC_MM: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(m_sel);
        mul_b     = OPND_W'(m_sel);
      end
      S_ACC_MV: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(v_sel);
        mul_b     = OPND_W'(m_sel);
      end
      S_RMS_DIV: begin
        div_start = (count_q != '0);
        div_n     = PROD_W'(sum_res_q[ch_q]);
        div_d     = PROD_W'(count_q);
      end
      S_RMS_SQRT: sqrt_start = 1'b1;
      S_FIT_NXX: begin
        mul_start = (count_q != '0);
        mul_a     = OPND_W'(sxx_sel);
        mul_b     = OPND_W'(count_q);
      end
      S_FIT_XX: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(sx_sel);
        mul_b     = OPND_W'(sx_sel);
      end
      S_FIT_DEN: begin
        mul_start = t0_gt;
        mul_a     = OPND_W'(sxy_sel);
        mul_b     = OPND_W'(count_q);
      end
      S_FIT_XY: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(sy_sel);
        mul_b     = OPND_W'(sx_sel);
      end
      S_FIT_BDIV: begin
        div_start = t0_gt;
        div_n     = b_num;
        div_d     = den_q;
      end
      S_FIT_BX: begin
        mul_start = 1'b1;
        mul_a     = OPND_W'(sx_sel);
        mul_b     = OPND_W'(bq_q);
      end
      S_FIT_ADIV: begin
        div_start = sy_gt;
        div_n     = a_num;
        div_d     = a_den;
      end
      default: ;
    endcase
  end

  rnmr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .p_o     (mul_p)
  );

  rnmr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .busy_o  (div_busy),
    .quot_o  (div_q)
  );

  rnmr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_v),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  // ---------------------------------------------------------------------------
  // Saturating accumulate helpers
  // ---------------------------------------------------------------------------
  function automatic logic [SMEAN_W-1:0] sat_add40(logic [SMEAN_W-1:0] acc,
                                                   logic [SMEAN_W-1:0] x);
    logic [SMEAN_W:0] s;
    s = {1'b0, acc} + {1'b0, x};
    return s[SMEAN_W] ? '1 : s[SMEAN_W-1:0];
  endfunction

  function automatic logic [SMSQ_W-1:0] sat_add56(logic [SMSQ_W-1:0] acc,
                                                  logic [SMSQ_W-1:0] x);
    logic [SMSQ_W:0] s;
    s = {1'b0, acc} + {1'b0, x};
    return s[SMSQ_W] ? '1 : s[SMSQ_W-1:0];
  endfunction

  function automatic logic [SRES_W-1:0] sat_add64(logic [SRES_W-1:0] acc,
                                                  logic [SRES_W-1:0] x);
    logic [SRES_W:0] s;
    s = {1'b0, acc} + {1'b0, x};
    return s[SRES_W] ? '1 : s[SRES_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result packing and output register
  // ---------------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] out_pack;
  logic [CMP_W-1:0]       cnt_ext;
  logic [KEPT_W-1:0]      kept;
  logic                   out_load, out_stall;

  assign cnt_ext   = CMP_W'(count_q);
  assign kept      = (cnt_ext > CMP_W'(KEPT_MAX)) ? '1 : KEPT_W'(cnt_ext);
  assign out_stall = (pass_q == PASS_REFIT) && out_valid_q && !m_axis_tready_i;
  assign out_load  = (state_q == S_PASS_DONE) && (pass_q == PASS_REFIT) && !out_stall;

  for (genvar g = 0; g < NUM_IN_CH; g++) begin : g_pack
    if (g < CHANNELS) begin : g_used
      assign out_pack[g*OFF_W +: OFF_W] = first_off_q[g];
      assign out_pack[NUM_IN_CH*OFF_W + g*SLOPE_W +: SLOPE_W] = first_slp_q[g];
    end else begin : g_unused
      // channels beyond CHANNELS report zero
      assign out_pack[g*OFF_W +: OFF_W] = '0;
      assign out_pack[NUM_IN_CH*OFF_W + g*SLOPE_W +: SLOPE_W] = '0;
    end
  end
  assign out_pack[NUM_IN_CH*(OFF_W+SLOPE_W) +: KEPT_W] = kept;
  assign out_pack[NUM_IN_CH*(OFF_W+SLOPE_W) + KEPT_W]  = degen_q || (count_q == '0);
  assign out_pack[OUT_TDATA_W-1:NUM_IN_CH*(OFF_W+SLOPE_W)+KEPT_W+1] = '0;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mean_q[c] <= s_axis_tdata_i[c*MEAN_W +: MEAN_W];
        var_q[c]  <= s_axis_tdata_i[NUM_IN_CH*MEAN_W + c*VAR_W +: VAR_W];
      end
    end
    if (out_load) out_q <= out_pack;
    case (state_q)
      S_ACC_MV: mm_q <= mul_p[2*MEAN_W-1:0];
      S_FIT_NXX: begin
        if (count_q == '0) begin
          aq_q <= OFF_W'(1);
          bq_q <= SLOPE_W'(1);
        end
      end
      S_FIT_XX: t0_q <= mul_p;
      S_FIT_DEN: begin
        den_q <= t0_q - mul_p;
        if (!t0_gt) begin
          aq_q <= OFF_W'(1);
          bq_q <= SLOPE_W'(1);
        end
      end
      S_FIT_XY: t0_q <= mul_p;
      S_FIT_BDIV: if (!t0_gt) bq_q <= SLOPE_W'(1);
      S_FIT_BQ:   bq_q <= bq_sat;
      S_FIT_ADIV: if (!sy_gt) aq_q <= OFF_W'(1);
      S_FIT_AQ:   aq_q <= aq_sat;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      pass_q      <= PASS_FIT;
      ch_q        <= '0;
      count_q     <= '0;
      keep_q      <= 1'b0;
      last_q      <= 1'b0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum_mean_q[c]  <= '0;
        sum_var_q[c]   <= '0;
        sum_msq_q[c]   <= '0;
        sum_mv_q[c]    <= '0;
        sum_res_q[c]   <= '0;
        first_off_q[c] <= '0;
        first_slp_q[c] <= '0;
        rms_q[c]       <= '0;
      end
    end else begin
      // drop the result once the sink takes the transfer, unless a new one loads now
      if (m_axis_tvalid_o && m_axis_tready_i && !out_load) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            keep_q <= in_keep;
            last_q <= s_axis_tlast_i;
            ch_q   <= '0;
            if (!in_keep)               state_q <= S_END;
            else if (pass_q == PASS_FIT) state_q <= S_ACC_MM;
            else                        state_q <= S_RES_MUL;
          end
        end

        S_RES_MUL: begin
          ret_q   <= S_RES_SQ;
          state_q <= S_WAIT;
        end

        S_RES_SQ: begin
          ret_q   <= S_RES_ACC;
          state_q <= S_WAIT;
        end

        S_RES_ACC: begin
          if (pass_q == PASS_RESID) begin
            sum_res_q[ch_q] <= sat_add64(sum_res_q[ch_q], mul_p[SRES_W-1:0]);
          end else if (sq_fail) begin
            keep_q <= 1'b0;
          end
          if (!ch_last) begin
            ch_q    <= ch_q + CH_W'(1);
            state_q <= S_RES_MUL;
          end else if (pass_q == PASS_RESID) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_END;
          end else if (keep_q && !sq_fail) begin
            // every channel is inside its RMS: refit with this sample
            ch_q    <= '0;
            state_q <= S_ACC_MM;
          end else begin
            state_q <= S_END;
          end
        end

        S_ACC_MM: begin
          ret_q   <= S_ACC_MV;
          state_q <= S_WAIT;
        end

        S_ACC_MV: begin
          ret_q   <= S_ACC_UPD;
          state_q <= S_WAIT;
        end

        S_ACC_UPD: begin
          sum_mean_q[ch_q] <= sat_add40(sx_sel, SMEAN_W'(m_sel));
          sum_var_q[ch_q]  <= sat_add40(sy_sel, SVAR_W'(v_sel));
          sum_msq_q[ch_q]  <= sat_add56(sxx_sel, SMSQ_W'(mm_q));
          sum_mv_q[ch_q]   <= sat_add56(sxy_sel, SMV_W'(mul_p[MEAN_W+VAR_W-1:0]));
          if (ch_last) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_END;
          end else begin
            ch_q    <= ch_q + CH_W'(1);
            state_q <= S_ACC_MM;
          end
        end

        S_END: begin
          ch_q <= '0;
          if (!last_q)                   state_q <= S_IDLE;
          else if (pass_q == PASS_RESID) state_q <= S_RMS_DIV;
          else                           state_q <= S_FIT_NXX;
        end

        S_RMS_DIV: begin
          if (count_q == '0) begin
            // empty residual pass: RMS stays zero
            rms_q[ch_q] <= '0;
            if (ch_last) state_q <= S_PASS_DONE;
            else         ch_q    <= ch_q + CH_W'(1);
          end else begin
            ret_q   <= S_RMS_SQRT;
            state_q <= S_WAIT;
          end
        end

        S_RMS_SQRT: begin
          ret_q   <= S_RMS_WR;
          state_q <= S_WAIT;
        end

        S_RMS_WR: begin
          rms_q[ch_q] <= sqrt_root;
          if (ch_last) begin
            state_q <= S_PASS_DONE;
          end else begin
            ch_q    <= ch_q + CH_W'(1);
            state_q <= S_RMS_DIV;
          end
        end

        S_FIT_NXX: begin
          if (count_q == '0) begin
            degen_q <= 1'b1;
            state_q <= S_FIT_WR;
          end else begin
            ret_q   <= S_FIT_XX;
            state_q <= S_WAIT;
          end
        end

        S_FIT_XX: begin
          ret_q   <= S_FIT_DEN;
          state_q <= S_WAIT;
        end

        S_FIT_DEN: begin
          if (!t0_gt) begin
            // denominator not positive
            degen_q <= 1'b1;
            state_q <= S_FIT_WR;
          end else begin
            ret_q   <= S_FIT_XY;
            state_q <= S_WAIT;
          end
        end

        S_FIT_XY: begin
          ret_q   <= S_FIT_BDIV;
          state_q <= S_WAIT;
        end

        S_FIT_BDIV: begin
          if (t0_gt) begin
            ret_q   <= S_FIT_BQ;
            state_q <= S_WAIT;
          end else begin
            state_q <= S_FIT_BX;
          end
        end

        S_FIT_BQ: state_q <= S_FIT_BX;

        S_FIT_BX: begin
          ret_q   <= S_FIT_ADIV;
          state_q <= S_WAIT;
        end

        S_FIT_ADIV: begin
          if (sy_gt) begin
            ret_q   <= S_FIT_AQ;
            state_q <= S_WAIT;
          end else begin
            state_q <= S_FIT_WR;
          end
        end

        S_FIT_AQ: state_q <= S_FIT_WR;

        S_FIT_WR: begin
          // the refit lands here too; the old model is no longer needed
          first_off_q[ch_q] <= aq_q;
          first_slp_q[ch_q] <= bq_q;
          if (ch_last) begin
            state_q <= S_PASS_DONE;
          end else begin
            ch_q    <= ch_q + CH_W'(1);
            state_q <= S_FIT_NXX;
          end
        end

        S_PASS_DONE: begin
          // hold while an earlier result still waits at the output
          if (!out_stall) begin
            count_q <= '0;
            degen_q <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
              sum_mean_q[c] <= '0;
              sum_var_q[c]  <= '0;
              sum_msq_q[c]  <= '0;
              sum_mv_q[c]   <= '0;
              sum_res_q[c]  <= '0;
            end
            case (pass_q)
              PASS_FIT:   pass_q <= PASS_RESID;
              PASS_RESID: pass_q <= PASS_REFIT;
              default: begin
                pass_q      <= PASS_FIT;
                out_valid_q <= 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                  first_off_q[c] <= '0;
                  first_slp_q[c] <= '0;
                  rms_q[c]       <= '0;
                end
              end
            endcase
            state_q <= S_IDLE;
          end
        end

        S_WAIT: if (!any_busy) state_q <= ret_q;

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_busy, div_busy, sqrt_busy}))
    else $error("more than one shared unit busy");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !any_busy)
    else $error("sample transfer taken while a unit is busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond limit");

  a_out_refit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pass_q) == PASS_REFIT) && (pass_q == PASS_FIT))
    else $error("result raised outside the end of the refit pass");

endmodule
